### hw/rtl/eire_pkg.sv
// shared types and constants of the event interval rate estimator
package eire_pkg;
	localparam int TIME_W = 48;
	localparam int FRAC_W = 16;
	localparam int PER_W  = 32;
	localparam int STR_W  = 64;
	localparam int NUM_W  = 81;
	localparam int DIV_W  = 64;
	localparam int MUL_W  = 32;

	localparam logic [1:0] ACT_EVENT  = 2'd0;
	localparam logic [1:0] ACT_RECALC = 2'd1;

	localparam logic       CFG_PERIOD = 1'b0;
	localparam logic       CFG_START  = 1'b1;

	typedef struct packed {
		logic [1:0]        action;
		logic [TIME_W-1:0] now_ms;
	} eire_in_t;

	typedef struct packed {
		logic [TIME_W-1:0] avg_interval;
		logic [TIME_W-1:0] min_avg_interval;
		logic [TIME_W-1:0] avg_events_per_period;
		logic [TIME_W-1:0] max_events_per_period;
		logic [STR_W-1:0]  strict_avg_interval;
		logic [TIME_W-1:0] strict_events_per_period;
		logic [TIME_W-1:0] event_total;
		logic [TIME_W-1:0] last_event_time;
	} eire_out_t;
endpackage

### hw/rtl/eire_mul.sv
// bit-serial shift-add multiplier that accumulates into a running sum
module eire_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       clr,
	input  logic [eire_pkg::NUM_W-1:0] mcand,
	input  logic [eire_pkg::MUL_W-1:0] mplier,
	output logic                       done,
	output logic [eire_pkg::NUM_W-1:0] acc
);
	import eire_pkg::*;

	logic [NUM_W-1:0] mcand_q;
	logic [MUL_W-1:0] mplier_q;
	logic [NUM_W-1:0] acc_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(MUL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			if (clr) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[NUM_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[MUL_W-1:1]};
		end
	end

	assign done = done_q;
	assign acc  = acc_q;
endmodule

### hw/rtl/eire_div.sv
// bit-serial restoring divider, 81 or 64 dividend bits
module eire_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       mode64,
	input  logic [eire_pkg::NUM_W-1:0] dividend,
	input  logic [eire_pkg::DIV_W-1:0] divisor,
	output logic                       done,
	output logic [eire_pkg::NUM_W-1:0] quo
);
	import eire_pkg::*;

	logic [NUM_W-1:0] dv_q;
	logic [NUM_W-1:0] quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dsr_q;
	logic [6:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, dv_q[NUM_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= mode64 ? 7'(DIV_W) : 7'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dv_q  <= mode64 ? {dividend[DIV_W-1:0], {(NUM_W-DIV_W){1'b0}}} : dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
			dv_q  <= {dv_q[NUM_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

### hw/rtl/event_interval_rate_estimator.sv
// event interval rate estimator: top level sequencer and state
// time from request to result is set by the serial divider (up to one 81-bit
//   division and four 64-bit divisions, one bit per cycle) and two multiply
//   passes; the input stalls until each result is loaded into the output register
// a new request is taken while the previous result waits in the output register
// reset clears averages, count, last event time, period to 60000 and start to 0
module event_interval_rate_estimator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  eire_pkg::eire_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output eire_pkg::eire_out_t  out_data,
	input  logic                 cfg_we,
	input  logic                 cfg_idx,
	input  logic [47:0]          cfg_data
);
	import eire_pkg::*;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PREP = 4'd1;
	localparam logic [3:0] S_MULA = 4'd2;
	localparam logic [3:0] S_MULB = 4'd3;
	localparam logic [3:0] S_DAVG = 4'd4;
	localparam logic [3:0] S_STR  = 4'd5;
	localparam logic [3:0] S_RAVG = 4'd6;
	localparam logic [3:0] S_RMIN = 4'd7;
	localparam logic [3:0] S_RSTR = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [3:0]        state_q;
	logic              go_q;
	logic              go_d;

	// configuration
	logic [PER_W-1:0]  period_q;
	logic [TIME_W-1:0] start_q;

	// persistent state
	logic [TIME_W-1:0] avg_q;
	logic [TIME_W-1:0] min_q;
	logic [TIME_W-1:0] last_q;
	logic [TIME_W-1:0] count_q;

	// per-request working registers
	logic [1:0]        action_q;
	logic [TIME_W-1:0] now_q;
	logic [PER_W-1:0]  iv_q;
	logic [PER_W-1:0]  pm_q;
	logic [PER_W-1:0]  p_q;
	logic [STR_W-1:0]  strict_q;
	logic [TIME_W-1:0] ravg_q;
	logic [TIME_W-1:0] rmin_q;
	logic [TIME_W-1:0] rstr_q;

	logic              out_valid_q;
	eire_out_t         out_q;

	// clamped period and interval
	logic [PER_W-1:0]  p_eff;
	logic [TIME_W-1:0] delta;
	logic [PER_W-1:0]  iv_c;

	// shared units
	logic              mul_start;
	logic              mul_clr;
	logic [NUM_W-1:0]  mul_mcand;
	logic [PER_W-1:0]  mul_mplier;
	logic              mul_done;
	logic [NUM_W-1:0]  mul_acc;

	logic              div_start;
	logic              div_mode64;
	logic [NUM_W-1:0]  div_dividend;
	logic [DIV_W-1:0]  div_divisor;
	logic              div_done;
	logic [NUM_W-1:0]  div_quo;
	logic [TIME_W-1:0] quo_sat;

	logic [NUM_W-1:0]  rate_dividend;
	logic              strict_ok;
	logic [TIME_W-1:0] new_avg;
	logic              out_free;

	assign p_eff = (period_q < PER_W'(2)) ? PER_W'(2) : period_q;
	assign delta = now_q - last_q;

	always_comb begin
		if (now_q <= last_q) begin
			iv_c = PER_W'(1);
		end else if (delta >= {{(TIME_W-PER_W){1'b0}}, p_eff}) begin
			iv_c = p_eff - PER_W'(1);
		end else begin
			iv_c = delta[PER_W-1:0];
		end
	end

	// rate dividend: period scaled by two fraction widths
	assign rate_dividend = {{(NUM_W-PER_W-2*FRAC_W){1'b0}}, period_q, {(2*FRAC_W){1'b0}}};
	assign quo_sat       = (div_quo[NUM_W-1:TIME_W] != '0) ? '1 : div_quo[TIME_W-1:0];
	assign strict_ok     = (now_q > start_q) && (count_q != '0);
	assign new_avg       = quo_sat;
	assign out_free      = !out_valid_q || !out_stall;

	// unit control
	always_comb begin
		mul_start    = 1'b0;
		mul_clr      = 1'b0;
		mul_mcand    = '0;
		mul_mplier   = '0;
		div_start    = 1'b0;
		div_mode64   = 1'b1;
		div_dividend = '0;
		div_divisor  = '0;
		unique case (state_q)
			S_MULA: begin
				mul_start  = go_q;
				mul_clr    = 1'b1;
				mul_mcand  = {{(NUM_W-TIME_W){1'b0}}, avg_q};
				mul_mplier = pm_q;
			end
			S_MULB: begin
				mul_start  = go_q;
				mul_mcand  = {{(NUM_W-PER_W-FRAC_W){1'b0}}, iv_q, {FRAC_W{1'b0}}};
				mul_mplier = iv_q;
			end
			S_DAVG: begin
				div_start    = go_q;
				div_mode64   = 1'b0;
				div_dividend = mul_acc;
				div_divisor  = {{(DIV_W-PER_W){1'b0}}, p_q};
			end
			S_STR: begin
				div_start    = go_q && strict_ok;
				div_dividend = {{(NUM_W-STR_W){1'b0}}, now_q - start_q, {FRAC_W{1'b0}}};
				div_divisor  = {{(DIV_W-TIME_W){1'b0}}, count_q};
			end
			S_RAVG: begin
				div_start    = go_q && (avg_q != '0);
				div_dividend = rate_dividend;
				div_divisor  = {{(DIV_W-TIME_W){1'b0}}, avg_q};
			end
			S_RMIN: begin
				div_start    = go_q && (min_q != '0);
				div_dividend = rate_dividend;
				div_divisor  = {{(DIV_W-TIME_W){1'b0}}, min_q};
			end
			S_RSTR: begin
				div_start    = go_q && (strict_q != '0);
				div_dividend = rate_dividend;
				div_divisor  = strict_q;
			end
			default: begin
			end
		endcase
	end

	// start pulse for the next step, raised in the cycle after a step ends
	always_comb begin
		unique case (state_q)
			S_PREP: go_d = 1'b1;
			S_MULA: go_d = mul_done;
			S_MULB: go_d = mul_done;
			S_DAVG: go_d = div_done;
			S_STR:  go_d = (go_q && !strict_ok) || div_done;
			S_RAVG: go_d = (go_q && avg_q == '0) || div_done;
			S_RMIN: go_d = (go_q && min_q == '0) || div_done;
			default: go_d = 1'b0;
		endcase
	end

	eire_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.clr    (mul_clr),
		.mcand  (mul_mcand),
		.mplier (mul_mplier),
		.done   (mul_done),
		.acc    (mul_acc)
	);

	eire_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.mode64   (div_mode64),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quo      (div_quo)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PER_W'(60000);
			start_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PERIOD: period_q <= cfg_data[PER_W-1:0];
				CFG_START:  start_q  <= cfg_data[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			go_q        <= 1'b0;
			avg_q       <= '0;
			min_q       <= '0;
			last_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			go_q        <= go_d;
			// result loads when the output register frees, else holds while stalled
			out_valid_q <= (state_q == S_OUT && out_free) || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					// query and the unused code skip the average update
					if (action_q == ACT_EVENT || action_q == ACT_RECALC) begin
						state_q <= S_MULA;
					end else begin
						state_q <= S_STR;
					end
				end
				S_MULA: begin
					if (mul_done) begin
						state_q <= S_MULB;
					end
				end
				S_MULB: begin
					if (mul_done) begin
						state_q <= S_DAVG;
					end
				end
				S_DAVG: begin
					if (div_done) begin
						avg_q <= new_avg;
						// a zero minimum means none seen yet
						if (new_avg < min_q || min_q == '0) begin
							min_q <= new_avg;
						end
						if (action_q == ACT_EVENT) begin
							last_q <= now_q;
							if (count_q != '1) begin
								count_q <= count_q + TIME_W'(1);
							end
						end
						state_q <= S_STR;
					end
				end
				S_STR: begin
					if ((go_q && !strict_ok) || div_done) begin
						state_q <= S_RAVG;
					end
				end
				S_RAVG: begin
					if ((go_q && avg_q == '0) || div_done) begin
						state_q <= S_RMIN;
					end
				end
				S_RMIN: begin
					if ((go_q && min_q == '0) || div_done) begin
						state_q <= S_RSTR;
					end
				end
				S_RSTR: begin
					if ((go_q && strict_q == '0) || div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				action_q <= in_data.action;
				now_q    <= in_data.now_ms;
			end
			S_PREP: begin
				iv_q     <= iv_c;
				pm_q     <= p_eff - iv_c;
				p_q      <= p_eff;
			end
			S_STR: begin
				if (go_q && !strict_ok) begin
					strict_q <= '0;
				end else if (div_done) begin
					strict_q <= div_quo[STR_W-1:0];
				end
			end
			S_RAVG: begin
				if (go_q && avg_q == '0) begin
					ravg_q <= '0;
				end else if (div_done) begin
					ravg_q <= quo_sat;
				end
			end
			S_RMIN: begin
				if (go_q && min_q == '0) begin
					rmin_q <= '0;
				end else if (div_done) begin
					rmin_q <= quo_sat;
				end
			end
			S_RSTR: begin
				if (go_q && strict_q == '0) begin
					rstr_q <= '0;
				end else if (div_done) begin
					rstr_q <= quo_sat;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_q.avg_interval             <= avg_q;
					out_q.min_avg_interval         <= min_q;
					out_q.avg_events_per_period    <= ravg_q;
					out_q.max_events_per_period    <= rmin_q;
					out_q.strict_avg_interval      <= strict_q;
					out_q.strict_events_per_period <= rstr_q;
					out_q.event_total              <= count_q;
					out_q.last_event_time          <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

### test/event_interval_rate_estimator_test.sv
// testbench of the event interval rate estimator: directed, config and random requests
`timescale 1ns / 100ps

module event_interval_rate_estimator_test;
	import eire_pkg::*;

	localparam logic [1:0]        ACT_QUERY  = 2'd2;
	localparam logic [1:0]        ACT_SPARE  = 2'd3;
	localparam logic [47:0]       TIME_MAX   = 48'hFFFF_FFFF_FFFF;
	localparam logic [63:0]       STRICT_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int                CYCLE_LIMIT = 3_000_000;
	localparam int                DRAIN_CYCLES = 600;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	eire_in_t    in_data;
	logic        out_valid;
	logic        out_stall;
	eire_out_t   out_data;
	logic        cfg_we;
	logic        cfg_idx;
	logic [47:0] cfg_data;

	event_interval_rate_estimator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// predictor state, mirrors the block's registers
	logic [31:0] period_reg;
	logic [47:0] start_reg;
	logic [47:0] avg_state;
	logic [47:0] min_state;
	logic [47:0] last_stamp;
	logic [47:0] event_count;

	eire_out_t   expected_reports[$];
	int          error_count;
	int          requests_sent;
	int          reports_seen;
	int          cycle_count;
	bit          quiet;          // no idling on either side when set
	int          hold_request;   // long receiver hold-off asked by the pressure test
	bit          report_taken;

	initial begin
		clk = 1'b0;
	end
	always #2 clk = ~clk;

	// period / interval in 32.16, saturating, zero for a zero interval
	function automatic logic [47:0] per_period_rate(input logic [63:0] iv);
		logic [127:0] q;
		if (iv == 64'd0) begin
			return 48'd0;
		end
		q = ({96'd0, period_reg} << 32) / {64'd0, iv};
		return (q > {80'd0, TIME_MAX}) ? TIME_MAX : q[47:0];
	endfunction

	// apply one request to the predictor state and return the expected report
	function automatic eire_out_t estimate_request(input logic [1:0] act,
			input logic [47:0] now);
		logic [63:0]  p;
		logic [63:0]  iv;
		logic [127:0] num;
		logic [127:0] q;
		logic [63:0]  strict;
		eire_out_t    r;
		strict = 64'd0;
		if (act == ACT_EVENT || act == ACT_RECALC) begin
			// periods below two behave as two in the average update
			p = (period_reg < 32'd2) ? 64'd2 : {32'd0, period_reg};
			if (now <= last_stamp) begin
				iv = 64'd1;
			end else begin
				iv = {16'd0, now - last_stamp};
				if (iv >= p) begin
					iv = p - 64'd1;
				end
			end
			num = {80'd0, avg_state} * {64'd0, p - iv} + ({64'd0, iv * iv} << 16);
			q = num / {64'd0, p};
			avg_state = (q > {80'd0, TIME_MAX}) ? TIME_MAX : q[47:0];
			// a zero minimum is always replaced
			if (avg_state < min_state || min_state == 48'd0) begin
				min_state = avg_state;
			end
			if (act == ACT_EVENT) begin
				last_stamp = now;
				if (event_count != TIME_MAX) begin
					event_count = event_count + 48'd1;
				end
			end
		end
		if (now > start_reg && event_count != 48'd0) begin
			q = ({80'd0, now - start_reg} << 16) / {80'd0, event_count};
			strict = (q > {64'd0, STRICT_MAX}) ? STRICT_MAX : q[63:0];
		end
		r.avg_interval             = avg_state;
		r.min_avg_interval         = min_state;
		r.avg_events_per_period    = per_period_rate({16'd0, avg_state});
		r.max_events_per_period    = per_period_rate({16'd0, min_state});
		r.strict_avg_interval      = strict;
		r.strict_events_per_period = per_period_rate(strict);
		r.event_total              = event_count;
		r.last_event_time          = last_stamp;
		return r;
	endfunction

	// receiver: random stall per report, plus the long hold-off on request
	int stall_left;
	int hold_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (report_taken) begin
				report_taken = 1'b0;
				stall_left   = quiet ? 0 : $urandom_range(0, 17);
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left = stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// checker: compare each accepted report with the oldest expectation
	always @(posedge clk) begin
		eire_out_t e;
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("event_interval_rate_estimator regression: fail");
			$finish;
		end else if (arst_n && out_valid && !out_stall) begin
			report_taken = 1'b1;
			reports_seen = reports_seen + 1;
			if (expected_reports.size() == 0) begin
				$error("report with no request pending");
				error_count = error_count + 1;
			end else begin
				e = expected_reports.pop_front();
				if (out_data.avg_interval !== e.avg_interval) begin
					$error("avg_interval exp %h got %h", e.avg_interval,
						out_data.avg_interval);
					error_count = error_count + 1;
				end
				if (out_data.min_avg_interval !== e.min_avg_interval) begin
					$error("min_avg_interval exp %h got %h", e.min_avg_interval,
						out_data.min_avg_interval);
					error_count = error_count + 1;
				end
				if (out_data.avg_events_per_period !== e.avg_events_per_period) begin
					$error("avg_events_per_period exp %h got %h",
						e.avg_events_per_period, out_data.avg_events_per_period);
					error_count = error_count + 1;
				end
				if (out_data.max_events_per_period !== e.max_events_per_period) begin
					$error("max_events_per_period exp %h got %h",
						e.max_events_per_period, out_data.max_events_per_period);
					error_count = error_count + 1;
				end
				if (out_data.strict_avg_interval !== e.strict_avg_interval) begin
					$error("strict_avg_interval exp %h got %h",
						e.strict_avg_interval, out_data.strict_avg_interval);
					error_count = error_count + 1;
				end
				if (out_data.strict_events_per_period !== e.strict_events_per_period) begin
					$error("strict_events_per_period exp %h got %h",
						e.strict_events_per_period, out_data.strict_events_per_period);
					error_count = error_count + 1;
				end
				if (out_data.event_total !== e.event_total) begin
					$error("event_total exp %h got %h", e.event_total,
						out_data.event_total);
					error_count = error_count + 1;
				end
				if (out_data.last_event_time !== e.last_event_time) begin
					$error("last_event_time exp %h got %h", e.last_event_time,
						out_data.last_event_time);
					error_count = error_count + 1;
				end
			end
		end
	end

	// offer one request after a random gap, predict it when it is taken
	task automatic send_request(input logic [1:0] act, input logic [47:0] now);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       = 1'b1;
		in_data.action = act;
		in_data.now_ms = now;
		do @(posedge clk); while (in_stall);
		expected_reports.push_back(estimate_request(act, now));
		requests_sent = requests_sent + 1;
		@(negedge clk);
	endtask

	// wait for all reports, then let the block settle
	task automatic drain();
		in_valid = 1'b0;
		while (expected_reports.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// register write while idle
	task automatic write_reg(input logic idx, input logic [47:0] value);
		drain();
		cfg_we   = 1'b1;
		cfg_idx  = idx;
		cfg_data = value;
		if (idx == CFG_PERIOD) begin
			period_reg = value[31:0];
		end else begin
			start_reg = value;
		end
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// extremes of the fields and every action with reset settings
	task automatic test_directed();
		quiet = 1'b1;
		send_request(ACT_QUERY, 48'd0);
		send_request(ACT_EVENT, 48'd0);          // time not advancing gives interval one
		send_request(ACT_EVENT, 48'd1000);
		send_request(ACT_RECALC, 48'd1500);
		send_request(ACT_EVENT, 48'd500);        // time going back
		send_request(ACT_EVENT, 48'd200000);     // interval clamped to period - 1
		send_request(ACT_SPARE, 48'd300000);     // spare code acts as a query
		quiet = 1'b0;
		send_request(ACT_QUERY, TIME_MAX);
		send_request(ACT_EVENT, TIME_MAX);
		send_request(ACT_RECALC, TIME_MAX);
		send_request(ACT_EVENT, 48'h5555_5555_5555);
		send_request(ACT_EVENT, 48'hAAAA_AAAA_AAAA);
		send_request(ACT_RECALC, 48'd0);
		send_request(ACT_QUERY, 48'd1);
	endtask

	// smallest and largest period, start at its extremes
	task automatic test_register_extremes();
		write_reg(CFG_PERIOD, 48'd2);
		write_reg(CFG_START, TIME_MAX);
		send_request(ACT_EVENT, TIME_MAX - 48'd5);
		send_request(ACT_EVENT, TIME_MAX);
		send_request(ACT_RECALC, TIME_MAX);
		write_reg(CFG_START, 48'd0);
		send_request(ACT_EVENT, 48'd3);
		write_reg(CFG_PERIOD, 48'hFFFF_FFFF);
		send_request(ACT_EVENT, 48'd10);
		send_request(ACT_EVENT, 48'h0001_0000_0000);
		send_request(ACT_RECALC, 48'h0002_0000_0000);
		send_request(ACT_QUERY, 48'h0002_0000_0001);
	endtask

	// mostly rising event streams with random spacing, some noise mixed in
	task automatic random_phase(input int count, input logic [47:0] base,
			input logic [31:0] spread);
		logic [47:0] now;
		logic [1:0]  act;
		int          pick;
		now = base;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				act = ACT_EVENT;
			end else if (pick < 82) begin
				act = ACT_RECALC;
			end else if (pick < 94) begin
				act = ACT_QUERY;
			end else begin
				act = ACT_SPARE;
			end
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				now = now + 48'($urandom_range(0, spread));
			end else if (pick < 93) begin
				now = now - 48'($urandom_range(0, spread));   // slips backward
			end else begin
				now = 48'({$urandom(), $urandom()});
			end
			send_request(act, now);
		end
	endtask

	task automatic test_random();
		logic [47:0] base;
		write_reg(CFG_PERIOD, 48'd60000);
		write_reg(CFG_START, 48'd0);
		random_phase(170, 48'd0, 32'd90000);
		quiet = 1'b1;
		random_phase(40, 48'd0, 32'd2000);
		quiet = 1'b0;
		write_reg(CFG_PERIOD, 48'd1000);
		base = 48'({$urandom(), $urandom()});
		write_reg(CFG_START, base - 48'd5000);
		random_phase(100, base, 32'd2500);
		write_reg(CFG_PERIOD, 48'd2);
		random_phase(40, base, 32'd3);
		write_reg(CFG_PERIOD, 48'hFFFF_FFFF);
		write_reg(CFG_START, {16'd0, $urandom()});
		random_phase(80, {16'h0, $urandom()}, 32'hFFFF_FFFF);
		write_reg(CFG_PERIOD, 48'($urandom_range(2, 32'hFFFF_FFFF)));
		write_reg(CFG_START, 48'({$urandom(), $urandom()}));
		random_phase(80, 48'({$urandom(), $urandom()}), 32'($urandom_range(1, 1 << 20)));
	endtask

	// receiver holds off long enough that the block stalls its input
	task automatic test_backpressure();
		write_reg(CFG_PERIOD, 48'd60000);
		hold_request = 3000;
		quiet = 1'b1;
		random_phase(12, 48'd1000, 32'd30000);
		quiet = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_we        = 1'b0;
		cfg_idx       = CFG_PERIOD;
		cfg_data      = '0;
		quiet         = 1'b0;
		hold_request  = 0;
		report_taken  = 1'b0;
		error_count   = 0;
		requests_sent = 0;
		reports_seen  = 0;
		cycle_count   = 0;
		period_reg    = 32'd60000;
		start_reg     = 48'd0;
		avg_state     = 48'd0;
		min_state     = 48'd0;
		last_stamp    = 48'd0;
		event_count   = 48'd0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_register_extremes();
		test_random();
		test_backpressure();

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered %0d requests and %0d reports over periods from 2 to 2^32-1,",
			requests_sent, reports_seen);
		$display("backward time, clamped intervals, spare action and a long output hold-off");
		if (error_count == 0 && expected_reports.size() == 0) begin
			$display("event_interval_rate_estimator regression: pass");
		end else begin
			$display("event_interval_rate_estimator regression: fail");
		end
		$finish;
	end
endmodule
